>>> hw/rtl/tsc_calibrated_deadline_timer_macros.svh
// Assertion macros for the calibrated deadline timer.
// Used by the port checker; expects clk and arst_n in the scope of use.
`ifndef TSC_CALIBRATED_DEADLINE_TIMER_MACROS_SVH
`define TSC_CALIBRATED_DEADLINE_TIMER_MACROS_SVH

// Same-cycle implication, off while in reset
`define TSCDT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer check failed");

// Next-cycle implication, off while in reset
`define TSCDT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer check failed");

`endif

>>> hw/rtl/tscdt_pkg.sv
// Shared types, codes and constant-divide helpers for the calibrated deadline timer.
// No dependencies; the timer top and step logic refer to it by scoped names, the testbench imports it.
package tscdt_pkg;

	// Calibration window and tick period
	localparam int unsigned CAL_TICKS   = 3;
	localparam int unsigned MS_PER_TICK = 10;
	localparam logic [23:0] GUARD_RESET = 24'd2000000;

	// Divide by CAL_TICKS*MS_PER_TICK through a reciprocal (32-bit dividend)
	localparam int unsigned CAL_DIV   = CAL_TICKS * MS_PER_TICK;
	localparam int unsigned CAL_SHIFT = $clog2(CAL_DIV);
	localparam logic [32:0] CAL_RECIP =
		33'(((65'd1 << (32 + CAL_SHIFT)) / CAL_DIV) + 65'd1);

	// Divide by MS_PER_TICK through a reciprocal (33-bit dividend)
	localparam int unsigned TICK_SHIFT = $clog2(MS_PER_TICK);
	localparam logic [33:0] TICK_RECIP =
		34'(((67'd1 << (33 + TICK_SHIFT)) / MS_PER_TICK) + 67'd1);

	typedef enum logic [2:0] {
		ACT_TICK  = 3'd0,
		ACT_START = 3'd1,
		ACT_POLL  = 3'd2,
		ACT_MAKE  = 3'd3,
		ACT_CHECK = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_EDGE    = 3'b010,
		PH_MEASURE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] cycle_now;
		logic [31:0] delay_ms;
		logic [63:0] deadline_in;
	} item_t;

	typedef struct packed {
		logic [63:0] deadline_out;
		logic        expired;
		logic        is_calibrated;
		logic        busy_calibrating;
		logic [31:0] rate_out;
		logic [31:0] tick_value;
	} result_t;

	typedef struct packed {
		logic [31:0] tick_count;
		phase_t      phase;
		logic [31:0] start_tick;
		logic [63:0] start_cycles;
		logic [23:0] guard_left;
		logic [31:0] cycles_per_ms;
		logic        calibrated;
	} state_t;

	// Elapsed cycles, clamped to 32 bits, divided by the window length in ms
	function automatic logic [31:0] cal_rate(input logic [63:0] elapsed);
		logic [31:0] e32;
		logic [64:0] prod;
		e32  = (elapsed[63:32] != 32'd0) ? 32'hFFFF_FFFF : elapsed[31:0];
		prod = 65'(e32) * 65'(CAL_RECIP);
		return prod[32 + CAL_SHIFT +: 32];
	endfunction

	// Milliseconds to ticks, rounded up, never below one
	function automatic logic [31:0] ms_to_ticks(input logic [31:0] ms);
		logic [32:0] num;
		logic [66:0] prod;
		logic [31:0] t;
		num  = 33'(ms) + 33'(MS_PER_TICK - 1);
		prod = 67'(num) * 67'(TICK_RECIP);
		t    = prod[33 + TICK_SHIFT +: 32];
		return (t == 32'd0) ? 32'd1 : t;
	endfunction

endpackage

>>> hw/rtl/tscdt_channels.sv
// Valid/ready channel interfaces: request, response and guard register write.
// Payload fields are plain logic vectors with the widths of the tscdt_pkg structs.
interface tscdt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [63:0] cycle_now;
	logic [31:0] delay_ms;
	logic [63:0] deadline_in;

	modport source (output valid, action, cycle_now, delay_ms, deadline_in, input ready);
	modport sink   (input valid, action, cycle_now, delay_ms, deadline_in, output ready);
endinterface

interface tscdt_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] deadline_out;
	logic        expired;
	logic        is_calibrated;
	logic        busy_calibrating;
	logic [31:0] rate_out;
	logic [31:0] tick_value;

	modport source (output valid, deadline_out, expired, is_calibrated, busy_calibrating,
		rate_out, tick_value, input ready);
	modport sink   (input valid, deadline_out, expired, is_calibrated, busy_calibrating,
		rate_out, tick_value, output ready);
endinterface

interface tscdt_cfg_if;
	logic        valid;
	logic        ready;
	logic [23:0] guard_limit;

	modport source (output valid, guard_limit, input ready);
	modport sink   (input valid, guard_limit, output ready);
endinterface

>>> hw/rtl/tsc_calibrated_deadline_timer.sv
// Top level of the calibrated deadline timer: input register, step logic, result register.
// Depends on tscdt_pkg, the channel interfaces and tscdt_step.
//
//  channel | dir | payload                                            | transfer when
//  req     | in  | action, cycle_now, delay_ms, deadline_in           | valid && ready
//  rsp     | out | deadline_out, expired, is_calibrated, busy, rate,  | valid && ready
//          |     | tick_value                                         |
//  cfg     | in  | guard_limit                                        | valid && ready
//
// One item per cycle while rsp is ready; path: input register, then result register.
// The step logic updates timer state as an item moves into the result register.
// A stalled response holds the result and backs pressure up through the input register.
// Reset clears all timer state; guard_limit returns to 2000000. cfg is always ready.
module tsc_calibrated_deadline_timer (
	input logic         clk,
	input logic         arst_n,
	tscdt_req_if.sink   req,
	tscdt_rsp_if.source rsp,
	tscdt_cfg_if.sink   cfg
);

	logic                valid_s1;
	tscdt_pkg::item_t    item_s1;
	logic                valid_s2;
	tscdt_pkg::result_t  result_s2;
	tscdt_pkg::state_t   state_q;
	tscdt_pkg::state_t   state_nxt;
	tscdt_pkg::result_t  result_nxt;
	logic [23:0]         guard_limit_q;
	logic                adv;

	// Handshake: stage 1 moves on when the result register is free or being emptied
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	// Guard register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_limit_q <= tscdt_pkg::GUARD_RESET;
		end else if (cfg.valid && cfg.ready) begin
			guard_limit_q <= cfg.guard_limit;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.action      <= req.action;
			item_s1.cycle_now   <= req.cycle_now;
			item_s1.delay_ms    <= req.delay_ms;
			item_s1.deadline_in <= req.deadline_in;
		end
	end

	tscdt_step u_step (
		.item        (item_s1),
		.cur         (state_q),
		.guard_limit (guard_limit_q),
		.nxt         (state_nxt),
		.res         (result_nxt)
	);

	// Timer state, committed as the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.tick_count    <= 32'd0;
			state_q.phase         <= tscdt_pkg::PH_IDLE;
			state_q.start_tick    <= 32'd0;
			state_q.start_cycles  <= 64'd0;
			state_q.guard_left    <= 24'd0;
			state_q.cycles_per_ms <= 32'd0;
			state_q.calibrated    <= 1'b0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= result_nxt;
		end
	end

	assign rsp.valid            = valid_s2;
	assign rsp.deadline_out     = result_s2.deadline_out;
	assign rsp.expired          = result_s2.expired;
	assign rsp.is_calibrated    = result_s2.is_calibrated;
	assign rsp.busy_calibrating = result_s2.busy_calibrating;
	assign rsp.rate_out         = result_s2.rate_out;
	assign rsp.tick_value       = result_s2.tick_value;

endmodule

>>> hw/rtl/tscdt_step.sv
// Single-pass next-state and result logic for one timer item.
// Depends on tscdt_pkg for types, codes and the constant-divide helpers.
module tscdt_step (
	input  tscdt_pkg::item_t   item,
	input  tscdt_pkg::state_t  cur,
	input  logic [23:0]        guard_limit,
	output tscdt_pkg::state_t  nxt,
	output tscdt_pkg::result_t res
);

	logic [31:0] tick_inc;
	logic [31:0] rate_new;
	logic [63:0] cyc_dl;
	logic [31:0] tick_dl;
	logic [63:0] cyc_diff;
	logic [31:0] tick_diff;

	// Arithmetic used by the action arms
	assign tick_inc  = cur.tick_count + 32'd1;
	assign rate_new  = tscdt_pkg::cal_rate(item.cycle_now - cur.start_cycles);
	assign cyc_dl    = item.cycle_now + (64'(item.delay_ms) * 64'(cur.cycles_per_ms));
	assign tick_dl   = cur.tick_count + tscdt_pkg::ms_to_ticks(item.delay_ms);
	assign cyc_diff  = item.cycle_now - item.deadline_in;
	assign tick_diff = cur.tick_count - item.deadline_in[31:0];

	// State update and result per action
	always_comb begin
		nxt = cur;
		res.deadline_out = 64'd0;
		res.expired      = 1'b0;
		unique case (tscdt_pkg::action_t'(item.action))
			tscdt_pkg::ACT_TICK: begin
				nxt.tick_count = tick_inc;
				if (cur.phase == tscdt_pkg::PH_EDGE) begin
					nxt.start_tick   = tick_inc;
					nxt.start_cycles = item.cycle_now;
					nxt.guard_left   = guard_limit;
					nxt.phase        = tscdt_pkg::PH_MEASURE;
				end else if (cur.phase == tscdt_pkg::PH_MEASURE &&
						(tick_inc - cur.start_tick) >= 32'(tscdt_pkg::CAL_TICKS)) begin
					nxt.cycles_per_ms = rate_new;
					nxt.calibrated    = (rate_new != 32'd0);
					nxt.phase         = tscdt_pkg::PH_IDLE;
				end
			end
			tscdt_pkg::ACT_START: begin
				nxt.start_tick = cur.tick_count;
				nxt.guard_left = guard_limit;
				nxt.phase      = tscdt_pkg::PH_EDGE;
			end
			tscdt_pkg::ACT_POLL: begin
				if (cur.phase != tscdt_pkg::PH_IDLE) begin
					if (cur.guard_left <= 24'd1) begin
						nxt.guard_left = 24'd0;
						nxt.calibrated = 1'b0;
						nxt.phase      = tscdt_pkg::PH_IDLE;
					end else begin
						nxt.guard_left = cur.guard_left - 24'd1;
					end
				end
			end
			tscdt_pkg::ACT_MAKE: begin
				res.deadline_out = cur.calibrated ? cyc_dl : {32'd0, tick_dl};
			end
			tscdt_pkg::ACT_CHECK: begin
				// wrap-safe: reached when the signed difference is not negative
				res.expired = cur.calibrated ? ~cyc_diff[63] : ~tick_diff[31];
			end
			default: begin
			end
		endcase
		res.is_calibrated    = nxt.calibrated;
		res.busy_calibrating = (nxt.phase != tscdt_pkg::PH_IDLE);
		res.rate_out         = nxt.cycles_per_ms;
		res.tick_value       = nxt.tick_count;
	end

endmodule

>>> hw/rtl/tscdt_checker.sv
// Port-level checker for the calibrated deadline timer, bound to the top level.
// Depends on tsc_calibrated_deadline_timer_macros.svh for the assertion macros.
`include "tsc_calibrated_deadline_timer_macros.svh"

module tscdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_is_calibrated,
	input logic [31:0] rsp_rate_out,
	input logic [31:0] rsp_tick_value,
	input logic [63:0] rsp_deadline_out
);

	logic rsp_xfer;

	assign rsp_xfer = rsp_valid && rsp_ready;

	// A stalled response stays valid and keeps its deadline and tick value
	`TSCDT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_deadline_out) && $stable(rsp_tick_value))

	// A calibrated timer never reports a zero rate
	`TSCDT_ASSERT_NOW(a_cal_rate, rsp_valid && rsp_is_calibrated, rsp_rate_out != 32'd0)

	// Back-to-back results: the tick count moves by at most one per item
	`TSCDT_ASSERT_NOW(a_tick_step, $past(rsp_xfer) && rsp_xfer, rsp_tick_value == $past(rsp_tick_value) || rsp_tick_value == $past(rsp_tick_value) + 32'd1)

endmodule

bind tsc_calibrated_deadline_timer tscdt_checker u_tscdt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_is_calibrated (rsp.is_calibrated),
	.rsp_rate_out      (rsp.rate_out),
	.rsp_tick_value    (rsp.tick_value),
	.rsp_deadline_out  (rsp.deadline_out)
);

>>> dv/tb_top.sv
// Self-checking testbench for tsc_calibrated_deadline_timer: directed and random transfers.
// Depends on tscdt_pkg, the tscdt channel interfaces and the timer RTL.
// An in-bench predictor tracks the timer state and checks every response in order.
module tb_top;
	import tscdt_pkg::*;

	localparam int unsigned WINDOW_MS = CAL_TICKS * MS_PER_TICK;
	localparam logic [2:0] ACT_UNUSED [3] = '{3'd5, 3'd6, 3'd7};

	// Predicted timer state and the queue of responses still owed by the block
	class timer_forecast;
		logic [23:0] guard_limit;
		logic [31:0] tick_cnt;
		phase_t      phase;
		logic [31:0] start_tick;
		logic [63:0] start_cycles;
		logic [23:0] guard_left;
		logic [31:0] rate;
		logic        calibrated;
		logic [63:0] last_deadline;
		result_t     due_results[$];
		int errors, n_requests, n_responses;
		int n_windows, n_zero_rate, n_clamped, n_guard_trips, n_expired;

		function new();
			guard_limit   = GUARD_RESET;
			tick_cnt      = '0;
			phase         = PH_IDLE;
			start_tick    = '0;
			start_cycles  = '0;
			guard_left    = '0;
			rate          = '0;
			calibrated    = 1'b0;
			last_deadline = '0;
		endfunction

		function void set_guard(logic [23:0] v);
			guard_limit = v;
		endfunction

		// One item through the timer; returns the response it should produce
		function result_t step_timer(item_t it);
			result_t     r;
			logic [63:0] span, diff64, ceil_ticks;
			logic [31:0] clamped, ticks, tick_gap, diff32;
			r = '0;
			case (it.action)
			ACT_TICK: begin
				tick_cnt = tick_cnt + 32'd1;
				if (phase == PH_EDGE) begin
					// edge seen: window opens here
					start_tick   = tick_cnt;
					start_cycles = it.cycle_now;
					guard_left   = guard_limit;
					phase        = PH_MEASURE;
				end else if (phase == PH_MEASURE) begin
					tick_gap = tick_cnt - start_tick;
					if (tick_gap >= 32'(CAL_TICKS)) begin
						span    = it.cycle_now - start_cycles;
						clamped = (span[63:32] != 32'd0) ? 32'hFFFF_FFFF : span[31:0];
						rate    = clamped / 32'(WINDOW_MS);
						calibrated = (rate != 32'd0);
						phase   = PH_IDLE;
						n_windows++;
						if (span[63:32] != 32'd0) n_clamped++;
						if (rate == 32'd0) n_zero_rate++;
					end
				end
			end
			ACT_START: begin
				start_tick = tick_cnt;
				guard_left = guard_limit;
				phase      = PH_EDGE;
			end
			ACT_POLL: begin
				if (phase != PH_IDLE) begin
					if (guard_left <= 24'd1) begin
						guard_left = '0;
						calibrated = 1'b0;
						phase      = PH_IDLE;
						n_guard_trips++;
					end else begin
						guard_left = guard_left - 24'd1;
					end
				end
			end
			ACT_MAKE: begin
				if (calibrated) begin
					r.deadline_out = it.cycle_now + 64'(it.delay_ms) * 64'(rate);
				end else begin
					// ms rounded up to whole ticks, at least one
					ceil_ticks = (64'(it.delay_ms) + 64'(MS_PER_TICK - 1)) / 64'(MS_PER_TICK);
					ticks = (ceil_ticks == 64'd0) ? 32'd1 : ceil_ticks[31:0];
					r.deadline_out = {32'd0, tick_cnt + ticks};
				end
				last_deadline = r.deadline_out;
			end
			ACT_CHECK: begin
				// wrap-safe: reached when the signed difference is not negative
				if (calibrated) begin
					diff64    = it.cycle_now - it.deadline_in;
					r.expired = ~diff64[63];
				end else begin
					diff32    = tick_cnt - it.deadline_in[31:0];
					r.expired = ~diff32[31];
				end
				if (r.expired) n_expired++;
			end
			default: ;
			endcase
			r.is_calibrated    = calibrated;
			r.busy_calibrating = (phase != PH_IDLE);
			r.rate_out         = rate;
			r.tick_value       = tick_cnt;
			return r;
		endfunction

		function void note_request(item_t it);
			n_requests++;
			due_results.push_back(step_timer(it));
		endfunction

		function void check_response(result_t got);
			result_t want;
			n_responses++;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("response %0d arrived with nothing owed: tick=%h rate=%h",
						n_responses, got.tick_value, got.rate_out);
				return;
			end
			want = due_results.pop_front();
			if (got.deadline_out !== want.deadline_out || got.expired !== want.expired ||
					got.is_calibrated !== want.is_calibrated ||
					got.busy_calibrating !== want.busy_calibrating ||
					got.rate_out !== want.rate_out || got.tick_value !== want.tick_value) begin
				errors++;
				if (errors <= 10) begin
					$display("response %0d expected: dl=%h exp=%b cal=%b busy=%b rate=%h tick=%h",
						n_responses, want.deadline_out, want.expired, want.is_calibrated,
						want.busy_calibrating, want.rate_out, want.tick_value);
					$display("response %0d actual:   dl=%h exp=%b cal=%b busy=%b rate=%h tick=%h",
						n_responses, got.deadline_out, got.expired, got.is_calibrated,
						got.busy_calibrating, got.rate_out, got.tick_value);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tscdt_req_if req_ch();
	tscdt_rsp_if rsp_ch();
	tscdt_cfg_if cfg_ch();

	tsc_calibrated_deadline_timer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	timer_forecast fc = new();

	logic [63:0] gen_cycles;
	int          src_idle_pct;
	int          sink_idle_pct;
	int          items_sent;
	int          guard_writes;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	// Response side back-pressure
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Watch all three channels for transfers
	always @(posedge clk) begin
		item_t   seen_req;
		result_t seen_rsp;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				fc.set_guard(cfg_ch.guard_limit);
			if (req_ch.valid && req_ch.ready) begin
				seen_req.action      = req_ch.action;
				seen_req.cycle_now   = req_ch.cycle_now;
				seen_req.delay_ms    = req_ch.delay_ms;
				seen_req.deadline_in = req_ch.deadline_in;
				fc.note_request(seen_req);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen_rsp.deadline_out     = rsp_ch.deadline_out;
				seen_rsp.expired          = rsp_ch.expired;
				seen_rsp.is_calibrated    = rsp_ch.is_calibrated;
				seen_rsp.busy_calibrating = rsp_ch.busy_calibrating;
				seen_rsp.rate_out         = rsp_ch.rate_out;
				seen_rsp.tick_value       = rsp_ch.tick_value;
				fc.check_response(seen_rsp);
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] pick_ms();
		case ($urandom_range(3))
		0: return 32'($urandom_range(0, 40));
		1: return 32'($urandom_range(0, 100000));
		2: return $urandom;
		default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// Cycles across a window: zero rate, normal rates, edge of clamp, clamped
	function automatic logic [63:0] pick_span();
		case ($urandom_range(9))
		0: return 64'($urandom_range(0, WINDOW_MS - 1));
		1: return 64'(WINDOW_MS * $urandom_range(1, 1000));
		2, 3, 4, 5: return 64'(WINDOW_MS * $urandom_range(1, 2000000) +
			$urandom_range(0, WINDOW_MS - 1));
		6: return 64'($urandom);
		7: return $urandom_range(1) ? 64'h0000_0000_FFFF_FFFF : 64'h0000_0001_0000_0000;
		8: return 64'h0000_0001_0000_0000 + 64'($urandom);
		default: return rand64();
		endcase
	endfunction

	// Deadlines near the interesting compare points
	function automatic logic [63:0] pick_deadline(input logic [63:0] now);
		logic [63:0] off;
		off = 64'($urandom_range(0, 8)) - 64'd4;
		case ($urandom_range(5))
		0: return fc.last_deadline + off;
		1: return now + off;
		2: return {$urandom, fc.tick_cnt + off[31:0]};
		3: return now + 64'h8000_0000_0000_0000 + off;
		4: return {$urandom, fc.tick_cnt + 32'h8000_0000 + off[31:0]};
		default: return rand64();
		endcase
	endfunction

	function automatic logic [23:0] pick_guard();
		case ($urandom_range(7))
		0: return 24'd1;
		1: return 24'd2;
		2: return 24'($urandom_range(3, 6));
		3: return 24'($urandom_range(7, 30));
		4: return 24'hFF_FFFF;
		5: return GUARD_RESET;
		default: return 24'($urandom);
		endcase
	endfunction

	// One request transfer, with an optional idle gap first
	task automatic push_item(input logic [2:0] act, input logic [63:0] now,
			input logic [31:0] ms, input logic [63:0] dl);
		if ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.action      <= act;
		req_ch.cycle_now   <= now;
		req_ch.delay_ms    <= ms;
		req_ch.deadline_in <= dl;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// Hold off until every owed response has come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (fc.due_results.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_guard(input logic [23:0] v);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.guard_limit <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		guard_writes++;
	endtask

	// Polls, deadline traffic and spare codes, inside a window or between windows
	task automatic filler(input logic [63:0] now);
		case ($urandom_range(5))
		0, 1, 2: push_item(ACT_POLL, now, $urandom, rand64());
		3: push_item(ACT_MAKE, now, pick_ms(), rand64());
		4: push_item(ACT_CHECK, now, $urandom, pick_deadline(now));
		default: push_item(ACT_UNUSED[$urandom_range(2)], now, $urandom, rand64());
		endcase
	endtask

	// Start, edge, CAL_TICKS more ticks, with traffic mixed in
	task automatic run_calibration();
		logic [63:0] base, span, step;
		int n;
		push_item(ACT_START, gen_cycles, pick_ms(), rand64());
		n = $urandom_range(0, 2);
		repeat (n) filler(gen_cycles);
		base = gen_cycles + 64'($urandom_range(1, 100));
		span = pick_span();
		step = span / 64'(CAL_TICKS);
		push_item(ACT_TICK, base, pick_ms(), rand64());
		for (int i = 1; i <= CAL_TICKS; i++) begin
			n = $urandom_range(0, 3);
			repeat (n) filler(base + step * 64'(i - 1) + 64'($urandom_range(0, 3)));
			if ($urandom_range(19) == 0)
				push_item(ACT_START, base, pick_ms(), rand64());
			push_item(ACT_TICK, (i == CAL_TICKS) ? base + span : base + step * 64'(i),
				pick_ms(), rand64());
		end
		gen_cycles = base + span;
		n = $urandom_range(1, 4);
		repeat (n) begin
			gen_cycles = gen_cycles + 64'($urandom_range(1, 500));
			if ($urandom_range(1))
				push_item(ACT_MAKE, gen_cycles, pick_ms(), rand64());
			else
				push_item(ACT_CHECK, gen_cycles, $urandom, pick_deadline(gen_cycles));
		end
	endtask

	// Anything at all, spare codes included
	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 4);
		repeat (n)
			push_item(3'($urandom_range(7)), $urandom_range(1) ? rand64() : gen_cycles,
				$urandom, rand64());
	endtask

	// Stimulus
	initial begin
		int phase_end;
		int seg_end;
		req_ch.valid       = 1'b0;
		req_ch.action      = ACT_TICK;
		req_ch.cycle_now   = '0;
		req_ch.delay_ms    = '0;
		req_ch.deadline_in = '0;
		rsp_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.guard_limit = '0;
		arst_n             = 1'b0;
		src_idle_pct       = 35;
		sink_idle_pct      = 50;
		items_sent         = 0;
		guard_writes       = 0;
		gen_cycles         = 64'd1000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// uncalibrated deadlines at the field extremes, idle poll, spare codes
		push_item(ACT_CHECK, 64'd0, 32'd0, 64'd0);
		push_item(ACT_CHECK, '1, '1, 64'h0000_0000_8000_0000);
		push_item(ACT_MAKE, 64'd100, 32'd0, '1);
		push_item(ACT_MAKE, 64'd100, 32'hFFFF_FFFF, 64'd0);
		push_item(ACT_MAKE, 64'd100, 32'd11, 64'd0);
		push_item(ACT_POLL, 64'd0, 32'd0, 64'd0);
		for (int i = 0; i < 3; i++)
			push_item(ACT_UNUSED[i], '1, '1, '1);

		// window too short: rate of zero
		push_item(ACT_START, 64'd1000, 32'd0, 64'd0);
		push_item(ACT_POLL, 64'd1500, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'd2000, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'd2010, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'd2020, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'd2029, 32'd0, 64'd0);

		// window across the 64-bit wrap, elapsed too wide: clamps
		push_item(ACT_START, 64'hFFFF_FFFF_FFFF_FE00, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'hFFFF_FFFF_FFFF_FF00, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'hFFFF_FFFF_FFFF_FF01, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'hFFFF_FFFF_FFFF_FF02, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'h0000_0001_FFFF_FF00, 32'd0, 64'd0);

		// calibrated deadlines and the signed compare boundaries
		push_item(ACT_MAKE, '1, 32'hFFFF_FFFF, 64'd0);
		push_item(ACT_CHECK, 64'h1234_5678_9ABC_DEF0, 32'd0, 64'h1234_5678_9ABC_DEF0);
		push_item(ACT_CHECK, 64'h1234_5678_9ABC_DEF0, 32'd0, 64'h1234_5678_9ABC_DEF1);
		push_item(ACT_CHECK, 64'h1234_5678_9ABC_DEF0, 32'd0, 64'h9234_5678_9ABC_DEF0);
		push_item(ACT_CHECK, 64'h1234_5678_9ABC_DEF0, 32'd0, 64'h9234_5678_9ABC_DEF1);

		// restart while measuring, then a clean window with a nonzero rate
		push_item(ACT_START, 64'd4000, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'd5000, 32'd0, 64'd0);
		push_item(ACT_START, 64'd5500, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'd6000, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'd7000, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'd8000, 32'd0, 64'd0);
		push_item(ACT_TICK, 64'd9000, 32'd0, 64'd0);

		// guard of one and of zero trip on the first poll, guard of two on the second
		drain_results();
		write_guard(24'd1);
		push_item(ACT_START, 64'd9100, 32'd0, 64'd0);
		push_item(ACT_POLL, 64'd9200, 32'd0, 64'd0);
		drain_results();
		write_guard(24'd0);
		push_item(ACT_START, 64'd9300, 32'd0, 64'd0);
		push_item(ACT_POLL, 64'd9400, 32'd0, 64'd0);
		drain_results();
		write_guard(24'd2);
		push_item(ACT_START, 64'd9500, 32'd0, 64'd0);
		push_item(ACT_POLL, 64'd9600, 32'd0, 64'd0);
		push_item(ACT_POLL, 64'd9700, 32'd0, 64'd0);
		gen_cycles = 64'd10000;

		// random part: three idling regimes, guard rewritten between segments
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
			0: begin
				src_idle_pct  = 35;
				sink_idle_pct = 50;
			end
			1: begin
				src_idle_pct  = 50;
				sink_idle_pct = 35;
			end
			default: begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			endcase
			phase_end = items_sent + 570;
			while (items_sent < phase_end) begin
				seg_end = items_sent + 90 + $urandom_range(0, 40);
				drain_results();
				write_guard(ph == 2 && items_sent + 130 >= phase_end ? 24'hFF_FFFF : pick_guard());
				while (items_sent < seg_end) begin
					case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: run_calibration();
					6, 7: begin
						gen_cycles = gen_cycles + 64'($urandom_range(1, 500));
						filler(gen_cycles);
					end
					default: noise_burst();
					endcase
				end
			end
		end

		// wind down and collect the stragglers
		req_ch.valid <= 1'b0;
		for (int w = 0; w < 5000 && fc.due_results.size() != 0; w++) @(posedge clk);
		repeat (6) @(posedge clk);
		if (fc.due_results.size() != 0) begin
			$display("%0d responses never arrived", fc.due_results.size());
			fc.errors += fc.due_results.size();
		end

		$display("summary: %0d requests, %0d responses, %0d guard writes, %0d errors",
			fc.n_requests, fc.n_responses, guard_writes, fc.errors);
		$display("summary: %0d windows closed (%0d zero rate, %0d clamped), %0d guard trips, %0d expired",
			fc.n_windows, fc.n_zero_rate, fc.n_clamped, fc.n_guard_trips, fc.n_expired);
		if (fc.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/tscdt_pkg.sv
hw/rtl/tscdt_channels.sv
hw/rtl/tscdt_step.sv
hw/rtl/tsc_calibrated_deadline_timer.sv
hw/rtl/tscdt_checker.sv
dv/tb_top.sv
